>>> design/serial_frame_receiver_assert.svh
// Assertion macros shared by the serial frame receiver RTL.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef SERIAL_FRAME_RECEIVER_ASSERT_SVH
`define SERIAL_FRAME_RECEIVER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFR_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("serial_frame_receiver: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SFR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("serial_frame_receiver: assertion failed");

`endif

>>> design/sfr_pkg.sv
// Types and constants of the serial frame receiver.
// No dependencies; used by serial_frame_receiver.
`timescale 1ns / 1ps

package sfr_pkg;

	localparam logic [7:0]  HDR_FIRST       = 8'h55;
	localparam logic [7:0]  HDR_SECOND      = 8'hAA;
	localparam logic [15:0] HEAD_BYTES      = 16'd6;
	localparam logic [15:0] MAX_FRAME_RESET = 16'd256;

	typedef enum logic [6:0] {
		PH_HUNT1 = 7'b0000001,
		PH_HUNT2 = 7'b0000010,
		PH_VER   = 7'b0000100,
		PH_CMD   = 7'b0001000,
		PH_LENH  = 7'b0010000,
		PH_LENL  = 7'b0100000,
		PH_DATA  = 7'b1000000
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE  = 3'd0,
		EV_DATA  = 3'd1,
		EV_GOOD  = 3'd2,
		EV_CSERR = 3'd3,
		EV_OVF   = 3'd4
	} event_t;

	typedef struct packed {
		event_t      event_res;
		logic [7:0]  data_byte;
		logic [15:0] payload_index;
		logic [7:0]  frame_version;
		logic [7:0]  frame_command;
		logic [15:0] payload_length;
	} result_t;

endpackage

>>> design/serial_frame_receiver.sv
// Serial frame receiver: one received byte in, one framing result out per transaction.
// Depends on sfr_pkg and serial_frame_receiver_assert.svh.
`timescale 1ns / 1ps

// Frames a byte stream of the form 0x55, 0xAA, version, command, 16-bit big-endian
// length, payload and an 8-bit additive checksum. Every input byte yields exactly one
// result transaction: nothing, a payload byte with its index, good frame, checksum
// error or overflow. The block takes one byte per clock cycle when the output is not
// stalled; a byte passes through the input register, then the result register, and
// its result waits there while the output is stalled. The rate is set by the update
// of the phase, byte count and running checksum, which every byte must see in order.
// max_frame_bytes (reset 256) may only be changed while no byte is in flight; once
// the header is matched, a byte arriving with the count at the limit ends the frame
// as an overflow and is dropped. No clearing pass is needed after reset.

`include "serial_frame_receiver_assert.svh"

module serial_frame_receiver (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write.
	input  logic        max_frame_bytes_we,
	input  logic [15:0] max_frame_bytes_wdata,
	// Input stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,    // [7:0] rx_byte
	// Result stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [2:0]  m_axis_tuser,    // [2:0] event_res
	output logic [55:0] m_axis_tdata     // [7:0] data_byte, [23:8] payload_index,
	                                     // [31:24] frame_version, [39:32] frame_command,
	                                     // [55:40] payload_length
);
	import sfr_pkg::*;

	logic [15:0] max_frame_q;
	phase_t      phase_q;
	logic [15:0] byte_count_q;
	logic [15:0] length_q;
	logic [7:0]  sum_q;
	logic [7:0]  version_q;
	logic [7:0]  command_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        valid_s2;
	result_t     res_s2;

	logic        advance;
	logic        process;

	phase_t      nxt_phase;
	logic [15:0] nxt_count;
	logic [15:0] nxt_length;
	logic [7:0]  nxt_sum;
	logic [7:0]  nxt_version;
	logic [7:0]  nxt_command;
	logic        end_frame;
	result_t     res;

	assign advance       = !valid_s2 || m_axis_tready;
	assign process       = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	always_comb begin
		nxt_phase         = phase_q;
		nxt_count         = byte_count_q;
		nxt_length        = length_q;
		nxt_sum           = sum_q;
		nxt_version       = version_q;
		nxt_command       = command_q;
		end_frame         = 1'b0;
		res.event_res     = EV_NONE;
		res.data_byte     = 8'd0;
		res.payload_index = 16'd0;
		case (phase_q)
			PH_HUNT1: begin
				if (byte_s1 == HDR_FIRST) begin
					nxt_count = byte_count_q + 16'd1;
					nxt_sum   = sum_q + byte_s1;
					nxt_phase = PH_HUNT2;
				end
			end
			PH_HUNT2: begin
				// A wrong second byte is not retried as a first header byte.
				if (byte_s1 == HDR_SECOND) begin
					nxt_count = byte_count_q + 16'd1;
					nxt_sum   = sum_q + byte_s1;
					nxt_phase = PH_VER;
				end else begin
					end_frame = 1'b1;
				end
			end
			default: begin
				if (byte_count_q >= max_frame_q) begin
					res.event_res = EV_OVF;
					end_frame     = 1'b1;
				end else begin
					nxt_count = byte_count_q + 16'd1;
					nxt_sum   = sum_q + byte_s1;
					case (phase_q)
						PH_VER: begin
							nxt_version = byte_s1;
							nxt_phase   = PH_CMD;
						end
						PH_CMD: begin
							nxt_command = byte_s1;
							nxt_phase   = PH_LENH;
						end
						PH_LENH: begin
							nxt_length = {byte_s1, 8'd0};
							nxt_phase  = PH_LENL;
						end
						PH_LENL: begin
							nxt_length = {length_q[15:8], byte_s1};
							nxt_phase  = PH_DATA;
						end
						default: begin
							// The byte after the declared payload is the checksum.
							if ({1'b0, byte_count_q} == ({1'b0, length_q} + {1'b0, HEAD_BYTES}))
							begin
								res.event_res = (sum_q == byte_s1) ? EV_GOOD : EV_CSERR;
								end_frame     = 1'b1;
							end else begin
								res.event_res     = EV_DATA;
								res.data_byte     = byte_s1;
								res.payload_index = byte_count_q - HEAD_BYTES;
							end
						end
					endcase
				end
			end
		endcase
		res.frame_version  = nxt_version;
		res.frame_command  = nxt_command;
		res.payload_length = nxt_length;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_q <= MAX_FRAME_RESET;
		end else if (max_frame_bytes_we) begin
			max_frame_q <= max_frame_bytes_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT1;
			byte_count_q <= 16'd0;
			length_q     <= 16'd0;
			sum_q        <= 8'd0;
			version_q    <= 8'd0;
			command_q    <= 8'd0;
		end else if (process) begin
			if (end_frame) begin
				phase_q      <= PH_HUNT1;
				byte_count_q <= 16'd0;
				length_q     <= 16'd0;
				sum_q        <= 8'd0;
				version_q    <= 8'd0;
				command_q    <= 8'd0;
			end else begin
				phase_q      <= nxt_phase;
				byte_count_q <= nxt_count;
				length_q     <= nxt_length;
				sum_q        <= nxt_sum;
				version_q    <= nxt_version;
				command_q    <= nxt_command;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = res_s2.event_res;
	assign m_axis_tdata  = {res_s2.payload_length, res_s2.frame_command, res_s2.frame_version,
	                        res_s2.payload_index, res_s2.data_byte};

	// While hunting for the first header byte, all frame state has been cleared.
	`SFR_ASSERT_IMP(a_hunt_clear, phase_q == PH_HUNT1,
		byte_count_q == 16'd0 && sum_q == 8'd0 && length_q == 16'd0)
	// Only the first header byte has been counted while waiting for the second.
	`SFR_ASSERT_IMP(a_hunt2_count, phase_q == PH_HUNT2,
		byte_count_q == 16'd1 && sum_q == HDR_FIRST)
	// A byte held in the input register reaches the result register when it is free.
	`SFR_ASSERT_NEXT(a_pipe_flow, valid_s1 && advance, valid_s2)
	// Data and index fields are zero unless the result carries a payload byte.
	`SFR_ASSERT_IMP(a_data_zero, valid_s2 && res_s2.event_res != EV_DATA,
		res_s2.data_byte == 8'd0 && res_s2.payload_index == 16'd0)

endmodule
